/* rtl/sidec_pkg.sv */
// shared types and constants for the signed integer to decimal text converter
// no dependencies

package sidec_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned DIGITS    = 10;
    localparam int unsigned BCD_W     = 4 * DIGITS;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned TOTAL_W   = 4;
    localparam int unsigned BITCNT_W  = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
    localparam logic [TOTAL_W-1:0] DIGITS_MAX = TOTAL_W'(DIGITS);
    localparam logic [TOTAL_W-1:0] CHARS_MAX  = 4'd11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_LOAD,
        ST_TRIM,
        ST_SIGN,
        ST_DIGS
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_conv_ctl;

    typedef struct packed {
        logic load;
        logic trim;
        logic emit_sign;
        logic emit_dig;
    } t_fmt_ctl;

    typedef struct packed {
        logic trim_more;
        logic last_dig;
    } t_fmt_sts;

endpackage

/* rtl/sidec_conv.sv */
// bit-serial binary to bcd converter (shift and add-3)
// depends on sidec_pkg

module sidec_conv (
    input  logic                           i_clk,
    input  sidec_pkg::t_conv_ctl           i_ctl,
    input  logic [sidec_pkg::VALUE_W-1:0]  i_value,
    output logic [sidec_pkg::BCD_W-1:0]    o_bcd,
    output logic                           o_neg
);

    logic [sidec_pkg::VALUE_W-1:0] r_mag, n_mag;
    logic [sidec_pkg::BCD_W-1:0]   r_bcd, n_bcd;
    logic                          r_neg, n_neg;
    logic [sidec_pkg::BCD_W-1:0]   w_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < sidec_pkg::DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        n_mag = r_mag;
        n_bcd = r_bcd;
        n_neg = r_neg;
        if (i_ctl.load) begin
            n_neg = i_value[sidec_pkg::VALUE_W-1];
            n_mag = i_value[sidec_pkg::VALUE_W-1] ? (~i_value + 32'd1) : i_value;
            n_bcd = '0;
        end else if (i_ctl.step) begin
            n_bcd = {w_adj[sidec_pkg::BCD_W-2:0], r_mag[sidec_pkg::VALUE_W-1]};
            n_mag = {r_mag[sidec_pkg::VALUE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
    end

    assign o_bcd = r_bcd;
    assign o_neg = r_neg;

endmodule

/* rtl/sidec_fmt.sv */
// leading zero removal and character emission, one digit per cycle
// depends on sidec_pkg

module sidec_fmt (
    input  logic                            i_clk,
    input  sidec_pkg::t_fmt_ctl             i_ctl,
    input  logic [sidec_pkg::BCD_W-1:0]     i_bcd,
    input  logic                            i_neg,
    output sidec_pkg::t_fmt_sts             o_sts,
    output logic [sidec_pkg::CHAR_W-1:0]    o_text_char,
    output logic                            o_last_char,
    output logic [sidec_pkg::TOTAL_W-1:0]   o_char_total
);

    logic [sidec_pkg::BCD_W-1:0]   r_digits, n_digits;
    logic [sidec_pkg::TOTAL_W-1:0] r_ndig, n_ndig;
    logic [sidec_pkg::TOTAL_W-1:0] r_left, n_left;
    logic [3:0]                    w_top;

    assign w_top = r_digits[sidec_pkg::BCD_W-1 -: 4];

    always_comb begin
        n_digits = r_digits;
        n_ndig   = r_ndig;
        n_left   = r_left;
        if (i_ctl.load) begin
            n_digits = i_bcd;
            n_ndig   = sidec_pkg::DIGITS_MAX;
            n_left   = sidec_pkg::DIGITS_MAX;
        end else if (i_ctl.trim || i_ctl.emit_dig) begin
            n_digits = {r_digits[sidec_pkg::BCD_W-5:0], 4'd0};
            n_left   = r_left - 4'd1;
            if (i_ctl.trim) begin
                n_ndig = r_ndig - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_ndig   <= n_ndig;
        r_left   <= n_left;
    end

    assign o_sts.trim_more = (w_top == 4'd0) && (r_ndig > 4'd1);
    assign o_sts.last_dig  = (r_left == 4'd1);

    assign o_text_char  = i_ctl.emit_sign ? sidec_pkg::CHAR_MINUS
                                          : sidec_pkg::CHAR_ZERO + {4'd0, w_top};
    assign o_last_char  = i_ctl.emit_dig && (r_left == 4'd1);
    assign o_char_total = r_ndig + {3'd0, i_neg};

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// top level: signed 32-bit integer to decimal ascii text, one character per strobe
// depends on sidec_pkg, sidec_conv, sidec_fmt

// A request is taken at a rising edge where start is high and busy is low. Busy then
// stays high until the last character has gone out. The magnitude is shifted into a bcd
// register one bit a cycle, then moved into the formatter. Leading zero digits are
// dropped one per cycle (0 to 9 of them), after which the first significant digit is
// found. Characters then leave one per cycle on o_text_char, a minus sign first for a
// negative value and then the digits most significant first, with o_char_valid high
// for exactly that cycle. The receiver cannot stall them. Dropped zeros plus digits
// always make ten. The next request can be accepted in the cycle after the last
// character. Every character carries the total character count and a flag on the
// last one.

module signed_int_to_decimal_ascii (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [sidec_pkg::VALUE_W-1:0]   i_value,
    output logic                            o_char_valid,
    output logic [sidec_pkg::CHAR_W-1:0]    o_text_char,
    output logic                            o_last_char,
    output logic [sidec_pkg::TOTAL_W-1:0]   o_char_total
);

    // last shift step of the conversion
    localparam logic [sidec_pkg::BITCNT_W-1:0] LAST_BIT =
        sidec_pkg::BITCNT_W'(sidec_pkg::VALUE_W - 1);

    sidec_pkg::t_state    r_state, n_state;
    logic [sidec_pkg::BITCNT_W-1:0] r_bit_cnt, n_bit_cnt;

    sidec_pkg::t_conv_ctl w_conv_ctl;
    sidec_pkg::t_fmt_ctl  w_fmt_ctl;
    sidec_pkg::t_fmt_sts  w_fmt_sts;
    logic [sidec_pkg::BCD_W-1:0] w_bcd;
    logic                        w_neg;
    logic                        w_accept;

    assign w_accept = start && (r_state == sidec_pkg::ST_IDLE);

    // next state
    always_comb begin
        n_state   = r_state;
        n_bit_cnt = r_bit_cnt;
        unique case (r_state)
            sidec_pkg::ST_IDLE: begin
                if (start) begin
                    n_state   = sidec_pkg::ST_CONV;
                    n_bit_cnt = '0;
                end
            end
            sidec_pkg::ST_CONV: begin
                n_bit_cnt = r_bit_cnt + 1'b1;
                if (r_bit_cnt == LAST_BIT) begin
                    n_state = sidec_pkg::ST_LOAD;
                end
            end
            sidec_pkg::ST_LOAD: begin
                n_state = sidec_pkg::ST_TRIM;
            end
            sidec_pkg::ST_TRIM: begin
                // drop leading zeros but always keep one digit
                if (!w_fmt_sts.trim_more) begin
                    n_state = w_neg ? sidec_pkg::ST_SIGN : sidec_pkg::ST_DIGS;
                end
            end
            sidec_pkg::ST_SIGN: begin
                n_state = sidec_pkg::ST_DIGS;
            end
            sidec_pkg::ST_DIGS: begin
                if (w_fmt_sts.last_dig) begin
                    n_state = sidec_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sidec_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb begin
        w_conv_ctl = '0;
        w_fmt_ctl  = '0;
        unique case (r_state)
            sidec_pkg::ST_IDLE: w_conv_ctl.load = start;
            sidec_pkg::ST_CONV: w_conv_ctl.step = 1'b1;
            sidec_pkg::ST_LOAD: w_fmt_ctl.load = 1'b1;
            sidec_pkg::ST_TRIM: w_fmt_ctl.trim = w_fmt_sts.trim_more;
            sidec_pkg::ST_SIGN: w_fmt_ctl.emit_sign = 1'b1;
            sidec_pkg::ST_DIGS: w_fmt_ctl.emit_dig = 1'b1;
            default: begin
                w_conv_ctl = '0;
                w_fmt_ctl  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sidec_pkg::ST_IDLE;
            r_bit_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
        end
    end

    sidec_conv u_conv (
        .i_clk   (i_clk),
        .i_ctl   (w_conv_ctl),
        .i_value (i_value),
        .o_bcd   (w_bcd),
        .o_neg   (w_neg)
    );

    sidec_fmt u_fmt (
        .i_clk        (i_clk),
        .i_ctl        (w_fmt_ctl),
        .i_bcd        (w_bcd),
        .i_neg        (w_neg),
        .o_sts        (w_fmt_sts),
        .o_text_char  (o_text_char),
        .o_last_char  (o_last_char),
        .o_char_total (o_char_total)
    );

    assign busy         = (r_state != sidec_pkg::ST_IDLE);
    assign o_char_valid = w_fmt_ctl.emit_sign || w_fmt_ctl.emit_dig;

    // a character only goes out inside a request
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char_valid |-> busy)
        else $error("character strobe outside a request");

    // the last character ends the request
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char_valid && o_last_char) |=> !busy)
        else $error("busy after last character");

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("request accepted but block not busy");

    // character count stays in range
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char_valid |-> (o_char_total >= 4'd1 && o_char_total <= sidec_pkg::CHARS_MAX))
        else $error("character total out of range");

    // the sign is never the last character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char_valid && o_text_char == sidec_pkg::CHAR_MINUS) |-> !o_last_char)
        else $error("sign marked as last character");

endmodule
